// ===== sv/ols_pkg.sv =====
// Package for the ordered list store: request codes, status codes, defaults.
// No dependencies.
`default_nettype none
package ols_pkg;
    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;
    localparam int REQ_W   = 3;
    localparam int POS_W   = 7;
    localparam int DIN_W   = 32;
    localparam int STAT_W  = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMVAL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMIDX = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd6;
    localparam logic [REQ_W-1:0] REQ_NOP    = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;
endpackage
`default_nettype wire

// ===== sv/ordered_list_store.sv =====
// Ordered list store: a CAPACITY-deep list of words in one synchronous RAM,
// served by a sequencer that reads, shifts and writes back one entry at a
// time and stalls new requests while it is busy. Push, pop, clear and refused
// requests go straight to the result; a read goes through the RAM read first.
// Insert moves each entry above the index up by one (one read, one write) and
// then writes the new word. Remove walks from the index, or from the start for
// remove by value, to the end of the list, then zeroes each vacated slot; a
// remove-every that empties the list is the worst case. The next request is
// taken the cycle after the result word leaves. Reset clears the state, the
// count and the output valid only; slots at and beyond the count are never
// read, and pop and clear leave them as they were. The result word waits in
// an output register.
// Depends on ols_pkg.
`default_nettype none
module ordered_list_store #(
    parameter int CAPACITY  = ols_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ols_pkg::WORD_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [ols_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [ols_pkg::POS_W-1:0]   i_position,
    input  wire logic [ols_pkg::DIN_W-1:0]   i_word_in,
    input  wire logic                        i_remove_every,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [ols_pkg::STAT_W-1:0]       o_status,
    output logic [ols_pkg::DIN_W-1:0]        o_word_out,
    output logic [ols_pkg::POS_W-1:0]        o_entry_count
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_WR   = 6'b000100,
        S_READ = 6'b001000,
        S_DONE = 6'b010000,
        S_ZERO = 6'b100000
    } t_state;

    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa, mem_ra;
    logic [WORD_BITS-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;        // read index
    logic [CW-1:0] r_w, n_w;        // write index (compaction) / insert target
    logic [WORD_BITS-1:0] r_hold, n_hold;
    logic [ols_pkg::REQ_W-1:0] r_req, n_req;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [CW-1:0] r_pos, n_pos;
    logic r_every, n_every, r_found, n_found;
    logic r_ovalid, n_ovalid;
    logic [ols_pkg::STAT_W-1:0] r_stat, n_stat;
    logic [WORD_BITS-1:0] r_out, n_out;

    logic [WORD_BITS-1:0] in_word;
    logic [ols_pkg::POS_W:0] pos_x, cnt_x;
    logic accept;

    assign in_word = WORD_BITS'(i_word_in);
    assign pos_x   = {1'b0, i_position};
    assign cnt_x   = (ols_pkg::POS_W+1)'(r_count);
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state = r_state; n_count = r_count; n_k = r_k; n_w = r_w;
        n_hold = r_hold; n_req = r_req; n_word = r_word; n_pos = r_pos;
        n_every = r_every; n_found = r_found; n_stat = r_stat; n_out = r_out;
        n_ovalid = r_ovalid;
        mem_we = 1'b0; mem_wa = r_w[AW-1:0]; mem_wd = r_hold;
        mem_ra = r_k[AW-1:0];
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_req_type; n_word = in_word; n_every = i_remove_every;
                    n_pos = CW'(i_position); n_stat = ols_pkg::ST_OK;
                    n_out = '0; n_found = 1'b0; n_state = S_DONE;
                    case (i_req_type)
                        ols_pkg::REQ_PUSH: begin
                            if (r_count >= CW'(CAPACITY)) n_stat = ols_pkg::ST_FULL;
                            else begin
                                mem_we = 1'b1; mem_wa = r_count[AW-1:0];
                                mem_wd = in_word; n_count = r_count + 1'b1;
                            end
                        end
                        ols_pkg::REQ_POP, ols_pkg::REQ_CLEAR: begin
                            if (r_count == '0) n_stat = ols_pkg::ST_EMPTY;
                            else if (i_req_type == ols_pkg::REQ_POP)
                                n_count = r_count - 1'b1;
                            else n_count = '0;
                        end
                        ols_pkg::REQ_INSERT: begin
                            if (pos_x > cnt_x) n_stat = ols_pkg::ST_RANGE;
                            else if (r_count >= CW'(CAPACITY))
                                n_stat = ols_pkg::ST_FULL;
                            else if (pos_x == cnt_x) begin
                                mem_we = 1'b1; mem_wa = r_count[AW-1:0];
                                mem_wd = in_word; n_count = r_count + 1'b1;
                            end else begin
                                // shift up from the top: read k-1, write k
                                n_w = r_count; n_k = r_count - 1'b1;
                                n_state = S_RD;
                            end
                        end
                        ols_pkg::REQ_REMVAL, ols_pkg::REQ_REMIDX: begin
                            if (r_count == '0) n_stat = ols_pkg::ST_EMPTY;
                            else if (i_req_type == ols_pkg::REQ_REMIDX &&
                                     pos_x >= cnt_x) n_stat = ols_pkg::ST_RANGE;
                            else begin
                                n_found = (i_req_type == ols_pkg::REQ_REMIDX);
                                n_k = (i_req_type == ols_pkg::REQ_REMIDX) ?
                                      CW'(i_position) : '0;
                                n_w = n_k;
                                n_state = S_RD;
                            end
                        end
                        ols_pkg::REQ_READ: begin
                            if (r_count == '0) n_stat = ols_pkg::ST_EMPTY;
                            else if (pos_x >= cnt_x) n_stat = ols_pkg::ST_RANGE;
                            else begin
                                mem_ra = i_position[AW-1:0];
                                n_state = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                // read of r_k issued this cycle
                n_state = S_WR;
            end
            S_WR: begin
                if (r_req == ols_pkg::REQ_INSERT) begin
                    mem_we = 1'b1; mem_wa = r_w[AW-1:0]; mem_wd = r_rdata;
                    if (r_k == r_pos) begin
                        n_hold = r_word; n_w = r_pos; n_state = S_ZERO;
                    end else begin
                        n_w = r_k; n_k = r_k - 1'b1; n_state = S_RD;
                    end
                end else begin
                    // compaction: r_w is the next write slot, r_k the slot read
                    if (r_k == r_pos && r_req == ols_pkg::REQ_REMIDX) begin
                        // target slot skipped
                    end else if (r_req == ols_pkg::REQ_REMVAL &&
                                 r_rdata == r_word && (r_every || !r_found)) begin
                        n_found = 1'b1;
                    end else begin
                        mem_we = 1'b1; mem_wa = r_w[AW-1:0]; mem_wd = r_rdata;
                        n_w = r_w + 1'b1;
                    end
                    if (r_k + 1'b1 >= r_count) begin
                        // r_k moves to the old count, the bound for zeroing
                        n_hold = '0; n_state = S_ZERO;
                        n_k = r_k + 1'b1; n_count = n_w;
                    end else begin
                        n_k = r_k + 1'b1; n_state = S_RD;
                    end
                end
            end
            S_ZERO: begin
                if (r_req == ols_pkg::REQ_INSERT) begin
                    mem_we = 1'b1; mem_wa = r_w[AW-1:0]; mem_wd = r_hold;
                    n_count = r_count + 1'b1; n_state = S_DONE;
                end else if (r_w < r_k) begin
                    // zero vacated slots above the compacted tail
                    mem_we = 1'b1; mem_wa = r_w[AW-1:0]; mem_wd = '0;
                    n_w = r_w + 1'b1;
                    if (n_w >= r_k) n_state = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_out = r_rdata; n_state = S_DONE;
            end
            S_DONE: begin
                n_ovalid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_ovalid <= n_ovalid;
        end
        r_k <= n_k; r_w <= n_w; r_hold <= n_hold; r_req <= n_req;
        r_word <= n_word; r_pos <= n_pos; r_every <= n_every;
        r_found <= n_found; r_stat <= n_stat; r_out <= n_out;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_stat;
    assign o_word_out    = ols_pkg::DIN_W'(r_out);
    assign o_entry_count = ols_pkg::POS_W'(r_count);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count beyond capacity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept) else $error("accept while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_ovalid) else $error("result lost");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
`endif
endmodule
`default_nettype wire
